FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the force progress LED bar.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/fplb_pkg.sv
// Package of the force progress LED bar: widths, levels, register indexes
// and the exponential coefficient table. No dependencies.
`timescale 1ns / 1ps

package fplb_pkg;

    localparam int COORD_W   = 24;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W + 1;
    localparam int D2_W      = SQ_W + 2;
    localparam int FORCE_W   = 16;
    localparam int LEVEL_W   = 8;
    localparam int IDLE_W    = 4;
    localparam int ROOT_W    = 17;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 4;
    localparam int MAG_W     = 9;
    localparam int EXP_TAPS  = 9;
    localparam int G_W       = 17;
    localparam int NUM_W     = 25;
    localparam int DEN_W     = 19;
    localparam int QUO_W     = 8;
    localparam int DIV_STEPS = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;
    localparam int SQRT_STAGES = 3;
    localparam int SQRT_STEPS  = 6;
    localparam int SEG_LAT   = 5;
    localparam int FORCE_LAT = 7;
    localparam int COLOR_LAT = EXP_TAPS + 1 + DIV_STAGES + 2;
    localparam int PIPE_LAT  = FORCE_LAT + COLOR_LAT;

    localparam logic [IDLE_W-1:0]  IDLE_LEVEL = 4'd10;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd180;
    localparam logic [ROOT_W-1:0]  MID_FORCE  = 17'd960;
    localparam logic [MAG_W-1:0]   SAT_SPAN   = 9'd256;
    localparam logic [G_W-1:0]     ONE_Q16    = 17'd65536;
    localparam logic [G_W-1:0]     HALF_Q16   = 17'd32768;
    localparam logic [NUM_W-1:0]   FULL_NUM   = 25'd23592960;
    localparam logic [8:0]         TWICE_FULL = 9'd360;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [FORCE_W-1:0] force_t;

    typedef enum logic [2:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_START_Z = 3'd2,
        CFG_END_X   = 3'd3,
        CFG_END_Y   = 3'd4,
        CFG_END_Z   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t sz;
        coord_t ex;
        coord_t ey;
        coord_t ez;
    } path_cfg_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
    } force_ofs_t;

    function automatic logic [15:0] exp_coef(input int unsigned idx);
        logic [15:0] c;
        case (idx)
            0:       c = 16'd63520;
            1:       c = 16'd61565;
            2:       c = 16'd57835;
            3:       c = 16'd51039;
            4:       c = 16'd39750;
            5:       c = 16'd24109;
            6:       c = 16'd8869;
            7:       c = 16'd1200;
            8:       c = 16'd22;
            default: c = 16'd0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/fplb_seg.sv
// Segment pipeline: squared distances, scaled compares and alignment delay.
// Depends on fplb_pkg.
`timescale 1ns / 1ps

module fplb_seg #(
    parameter int NUM_SEGMENTS = 5,
    parameter int SEG_W        = 3
) (
    input  logic                clk,
    input  logic                en,
    input  fplb_pkg::path_cfg_t cfg,
    input  fplb_pkg::coord_t    pos_x,
    input  fplb_pkg::coord_t    pos_y,
    input  fplb_pkg::coord_t    pos_z,
    output logic [SEG_W-1:0]    seg
);

    localparam int PROD_W  = fplb_pkg::D2_W + 2 * SEG_W + 1;
    localparam int DELAY   = fplb_pkg::PIPE_LAT - fplb_pkg::SEG_LAT;

    logic signed [fplb_pkg::DIFF_W-1:0] dp_reg [3];
    logic signed [fplb_pkg::DIFF_W-1:0] dl_reg [3];
    logic [fplb_pkg::SQ_W-1:0]          sp_reg [3];
    logic [fplb_pkg::SQ_W-1:0]          sl_reg [3];
    logic [fplb_pkg::D2_W-1:0]          d2_reg;
    logic [fplb_pkg::D2_W-1:0]          l2_reg;
    logic [PROD_W-1:0]                  lhs_reg;
    logic [PROD_W-1:0]                  rhs_reg [NUM_SEGMENTS];
    logic [SEG_W-1:0]                   cnt_reg;
    logic [SEG_W-1:0]                   cnt_next;
    logic [SEG_W-1:0]                   dly_reg [DELAY];
    logic signed [2*fplb_pkg::DIFF_W-1:0] sqp [3];
    logic signed [2*fplb_pkg::DIFF_W-1:0] sql [3];

    function automatic logic signed [fplb_pkg::DIFF_W-1:0] DIFF_W_EXT(
        input fplb_pkg::coord_t v);
        return {v[fplb_pkg::COORD_W-1], v};
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sqp[i] = dp_reg[i] * dp_reg[i];
            sql[i] = dl_reg[i] * dl_reg[i];
        end
    end

    always_comb
    begin
        cnt_next = '0;
        for (int k = 1; k < NUM_SEGMENTS; k++)
        begin
            if (lhs_reg >= rhs_reg[k])
            begin
                cnt_next = cnt_next + SEG_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dp_reg[0] <= DIFF_W_EXT(pos_x) - DIFF_W_EXT(cfg.sx);
            dp_reg[1] <= DIFF_W_EXT(pos_y) - DIFF_W_EXT(cfg.sy);
            dp_reg[2] <= DIFF_W_EXT(pos_z) - DIFF_W_EXT(cfg.sz);
            dl_reg[0] <= DIFF_W_EXT(cfg.ex) - DIFF_W_EXT(cfg.sx);
            dl_reg[1] <= DIFF_W_EXT(cfg.ey) - DIFF_W_EXT(cfg.sy);
            dl_reg[2] <= DIFF_W_EXT(cfg.ez) - DIFF_W_EXT(cfg.sz);
            for (int i = 0; i < 3; i++)
            begin
                sp_reg[i] <= sqp[i][fplb_pkg::SQ_W-1:0];
                sl_reg[i] <= sql[i][fplb_pkg::SQ_W-1:0];
            end
            d2_reg <= fplb_pkg::D2_W'(sp_reg[0]) + fplb_pkg::D2_W'(sp_reg[1])
                    + fplb_pkg::D2_W'(sp_reg[2]);
            l2_reg <= fplb_pkg::D2_W'(sl_reg[0]) + fplb_pkg::D2_W'(sl_reg[1])
                    + fplb_pkg::D2_W'(sl_reg[2]);
            lhs_reg <= PROD_W'(d2_reg) * PROD_W'(NUM_SEGMENTS * NUM_SEGMENTS);
            for (int k = 0; k < NUM_SEGMENTS; k++)
            begin
                rhs_reg[k] <= PROD_W'(l2_reg) * PROD_W'(k * k);
            end
            cnt_reg <= cnt_next;
            dly_reg[0] <= cnt_reg;
            for (int j = 1; j < DELAY; j++)
            begin
                dly_reg[j] <= dly_reg[j-1];
            end
        end
    end

    assign seg = dly_reg[DELAY-1];

endmodule

FILE: rtl/fplb_force.sv
// Force magnitude pipeline: squares, staged integer square root, offset and
// clamp around the midpoint. Depends on fplb_pkg.
`timescale 1ns / 1ps

module fplb_force (
    input  logic                  clk,
    input  logic                  en,
    input  fplb_pkg::force_t      force_x,
    input  fplb_pkg::force_t      force_z,
    output fplb_pkg::force_ofs_t  ofs
);

    localparam int RW = fplb_pkg::REM_W;
    localparam int QW = fplb_pkg::ROOT_W;

    logic [fplb_pkg::FORCE_W-1:0]  ax_reg;
    logic [fplb_pkg::FORCE_W-1:0]  az_reg;
    logic [2*fplb_pkg::FORCE_W-1:0] sx_reg;
    logic [2*fplb_pkg::FORCE_W-1:0] sz_reg;
    logic [fplb_pkg::RAD_W-1:0]    rad_reg [fplb_pkg::SQRT_STAGES+1];
    logic [RW-1:0]                 rem_reg [fplb_pkg::SQRT_STAGES+1];
    logic [QW-1:0]                 root_reg [fplb_pkg::SQRT_STAGES+1];
    logic [RW-1:0]                 rem_next [fplb_pkg::SQRT_STAGES];
    logic [QW-1:0]                 root_next [fplb_pkg::SQRT_STAGES];
    fplb_pkg::force_ofs_t          ofs_reg;
    fplb_pkg::force_ofs_t          ofs_next;
    logic [QW:0]                   rnd;
    logic signed [QW+1:0]          t;

    for (genvar s = 0; s < fplb_pkg::SQRT_STAGES; s++)
    begin : g_sqrt
        localparam int HI = QW - 1 - s * fplb_pkg::SQRT_STEPS;
        localparam int LO = (HI - fplb_pkg::SQRT_STEPS + 1 < 0) ? 0
                          : HI - fplb_pkg::SQRT_STEPS + 1;
        always_comb
        begin
            logic [RW-1:0] r;
            logic [QW-1:0] q;
            logic [RW-1:0] trial;
            r = rem_reg[s];
            q = root_reg[s];
            for (int i = HI; i >= LO; i--)
            begin
                r = {r[RW-3:0], rad_reg[s][2*i +: 2]};
                trial = RW'({q, 2'b01});
                if (r >= trial)
                begin
                    r = r - trial;
                    q = {q[QW-2:0], 1'b1};
                end
                else
                begin
                    q = {q[QW-2:0], 1'b0};
                end
            end
            rem_next[s]  = r;
            root_next[s] = q;
        end
    end

    always_comb
    begin
        rnd = ({1'b0, root_reg[fplb_pkg::SQRT_STAGES]} + (QW+1)'(1)) >> 1;
        t   = $signed({1'b0, rnd}) - $signed((QW+2)'(fplb_pkg::MID_FORCE));
        if (t > $signed((QW+2)'(fplb_pkg::SAT_SPAN)))
        begin
            ofs_next.mag = fplb_pkg::SAT_SPAN;
            ofs_next.neg = 1'b0;
        end
        else if (t < -$signed((QW+2)'(fplb_pkg::SAT_SPAN)))
        begin
            ofs_next.mag = fplb_pkg::SAT_SPAN;
            ofs_next.neg = 1'b1;
        end
        else if (t < 0)
        begin
            ofs_next.mag = fplb_pkg::MAG_W'(-t);
            ofs_next.neg = 1'b1;
        end
        else
        begin
            ofs_next.mag = fplb_pkg::MAG_W'(t);
            ofs_next.neg = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= force_x[fplb_pkg::FORCE_W-1] ? fplb_pkg::FORCE_W'(-force_x)
                                                  : fplb_pkg::FORCE_W'(force_x);
            az_reg <= force_z[fplb_pkg::FORCE_W-1] ? fplb_pkg::FORCE_W'(-force_z)
                                                  : fplb_pkg::FORCE_W'(force_z);
            sx_reg <= ax_reg * ax_reg;
            sz_reg <= az_reg * az_reg;
            rad_reg[0]  <= (fplb_pkg::RAD_W'(sx_reg) + fplb_pkg::RAD_W'(sz_reg)) << 2;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            for (int s = 0; s < fplb_pkg::SQRT_STAGES; s++)
            begin
                rad_reg[s+1]  <= rad_reg[s];
                rem_reg[s+1]  <= rem_next[s];
                root_reg[s+1] <= root_next[s];
            end
            ofs_reg <= ofs_next;
        end
    end

    assign ofs = ofs_reg;

endmodule

FILE: rtl/fplb_color.sv
// Color pipeline: exponential by one coefficient multiply per stage, then a
// restoring divider over several stages for the red level. Depends on fplb_pkg.
`timescale 1ns / 1ps

module fplb_color (
    input  logic                          clk,
    input  logic                          en,
    input  fplb_pkg::force_ofs_t          ofs,
    output logic [fplb_pkg::LEVEL_W-1:0]  red,
    output logic [fplb_pkg::LEVEL_W-1:0]  green
);

    localparam int NT = fplb_pkg::EXP_TAPS;
    localparam int ND = fplb_pkg::DIV_STAGES;
    localparam int WW = fplb_pkg::DEN_W + fplb_pkg::QUO_W;

    logic [fplb_pkg::G_W-1:0]     g_reg   [NT+1];
    fplb_pkg::force_ofs_t         o_reg   [NT+1];
    logic [fplb_pkg::G_W-1:0]     g_next  [NT];
    logic [fplb_pkg::NUM_W-1:0]   num_reg [ND+1];
    logic [fplb_pkg::DEN_W-1:0]   den_reg [ND+1];
    logic [fplb_pkg::QUO_W-1:0]   quo_reg [ND+1];
    logic [fplb_pkg::NUM_W-1:0]   num_next [ND];
    logic [fplb_pkg::QUO_W-1:0]   quo_next [ND];
    logic [fplb_pkg::DEN_W-1:0]   den_half;
    logic [fplb_pkg::LEVEL_W-1:0] red_reg;
    logic [fplb_pkg::LEVEL_W-1:0] green_reg;
    logic [fplb_pkg::LEVEL_W-1:0] red_next;

    for (genvar i = 0; i < NT; i++)
    begin : g_exp
        logic [2*fplb_pkg::G_W-1:0] prod;
        assign prod = g_reg[i] * (2*fplb_pkg::G_W)'(fplb_pkg::exp_coef(i))
                    + (2*fplb_pkg::G_W)'(fplb_pkg::HALF_Q16);
        assign g_next[i] = o_reg[i].mag[i] ? prod[16 +: fplb_pkg::G_W] : g_reg[i];
    end

    for (genvar s = 0; s < ND; s++)
    begin : g_div
        always_comb
        begin
            logic [WW-1:0]              r;
            logic [WW-1:0]              d;
            logic [fplb_pkg::QUO_W-1:0] q;
            r = WW'(num_reg[s]);
            q = quo_reg[s];
            for (int j = 0; j < fplb_pkg::DIV_STEPS; j++)
            begin
                d = WW'(den_reg[s]) << (fplb_pkg::QUO_W - 1 - s * fplb_pkg::DIV_STEPS - j);
                if (r >= d)
                begin
                    r = r - d;
                    q[fplb_pkg::QUO_W - 1 - s * fplb_pkg::DIV_STEPS - j] = 1'b1;
                end
            end
            num_next[s] = fplb_pkg::NUM_W'(r);
            quo_next[s] = q;
        end
    end

    assign den_half = fplb_pkg::DEN_W'(fplb_pkg::ONE_Q16) + fplb_pkg::DEN_W'(g_reg[NT]);
    assign red_next = (quo_reg[ND] > fplb_pkg::FULL_LEVEL) ? fplb_pkg::FULL_LEVEL
                                                          : quo_reg[ND];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg[0] <= fplb_pkg::ONE_Q16;
            o_reg[0] <= ofs;
            for (int i = 0; i < NT; i++)
            begin
                g_reg[i+1] <= g_next[i];
                o_reg[i+1] <= o_reg[i];
            end
            num_reg[0] <= (o_reg[NT].neg
                           ? fplb_pkg::NUM_W'(g_reg[NT]) * fplb_pkg::NUM_W'(fplb_pkg::TWICE_FULL)
                           : fplb_pkg::FULL_NUM)
                        + fplb_pkg::NUM_W'(den_half);
            den_reg[0] <= den_half << 1;
            quo_reg[0] <= '0;
            for (int s = 0; s < ND; s++)
            begin
                num_reg[s+1] <= num_next[s];
                den_reg[s+1] <= den_reg[s];
                quo_reg[s+1] <= quo_next[s];
            end
            red_reg   <= red_next;
            green_reg <= fplb_pkg::FULL_LEVEL - red_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;

endmodule

FILE: rtl/force_progress_led_bar_core.sv
// Top level of the force progress LED bar: path registers, handshake and
// valid chain. Depends on fplb_pkg, fplb_seg, fplb_force, fplb_color.
//
//  channel | signals                                 | direction
//  in      | in_valid, in_stall, pos_*, force_*      | item in
//  out     | out_valid, out_stall, lit_segment, ...  | result out
//  cfg     | cfg_valid, cfg_ready, cfg_index, data   | register write
//
// One transaction per cycle while no valid result is held by a stalled output;
// the force path has square root stages, nine exponential multiplies, divider.
// Reset clears the path registers to zero and empties the valid chain.
// A stalled output holding a valid result freezes the whole pipeline and stalls the input.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module force_progress_led_bar_core #(
    parameter int NUM_SEGMENTS = 5,
    parameter int SEG_W        = $clog2(NUM_SEGMENTS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  fplb_pkg::coord_t              pos_x,
    input  fplb_pkg::coord_t              pos_y,
    input  fplb_pkg::coord_t              pos_z,
    input  fplb_pkg::force_t              force_x,
    input  fplb_pkg::force_t              force_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [SEG_W-1:0]              lit_segment,
    output logic [fplb_pkg::LEVEL_W-1:0]  red_level,
    output logic [fplb_pkg::LEVEL_W-1:0]  green_level,
    output logic [fplb_pkg::IDLE_W-1:0]   idle_level,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  fplb_pkg::coord_t              cfg_data
);

    fplb_pkg::path_cfg_t          cfg_reg;
    logic [fplb_pkg::PIPE_LAT-1:0] vld_reg;
    logic                         adv;
    fplb_pkg::force_ofs_t         ofs;
    logic [fplb_pkg::LEVEL_W:0]   level_sum;

    assign adv       = !(vld_reg[fplb_pkg::PIPE_LAT-1] && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;
    assign out_valid = vld_reg[fplb_pkg::PIPE_LAT-1];
    assign idle_level = fplb_pkg::IDLE_LEVEL;
    assign level_sum = {1'b0, red_level} + {1'b0, green_level};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (fplb_pkg::cfg_reg_t'(cfg_index))
                fplb_pkg::CFG_START_X: cfg_reg.sx <= cfg_data;
                fplb_pkg::CFG_START_Y: cfg_reg.sy <= cfg_data;
                fplb_pkg::CFG_START_Z: cfg_reg.sz <= cfg_data;
                fplb_pkg::CFG_END_X:   cfg_reg.ex <= cfg_data;
                fplb_pkg::CFG_END_Y:   cfg_reg.ey <= cfg_data;
                fplb_pkg::CFG_END_Z:   cfg_reg.ez <= cfg_data;
                default:               cfg_reg    <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[fplb_pkg::PIPE_LAT-2:0], in_valid};
        end
    end

    fplb_seg #(
        .NUM_SEGMENTS (NUM_SEGMENTS),
        .SEG_W        (SEG_W)
    ) u_seg (
        .clk   (clk),
        .en    (adv),
        .cfg   (cfg_reg),
        .pos_x (pos_x),
        .pos_y (pos_y),
        .pos_z (pos_z),
        .seg   (lit_segment)
    );

    fplb_force u_force (
        .clk     (clk),
        .en      (adv),
        .force_x (force_x),
        .force_z (force_z),
        .ofs     (ofs)
    );

    fplb_color u_color (
        .clk   (clk),
        .en    (adv),
        .ofs   (ofs),
        .red   (red_level),
        .green (green_level)
    );

    `ASSERT_IMPLIES(a_levels_sum, clk, rst_n, out_valid, level_sum == 9'd180)
    `ASSERT_IMPLIES(a_seg_range, clk, rst_n, out_valid, 32'(lit_segment) < NUM_SEGMENTS)
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
    `ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && out_stall, out_valid)

endmodule

FILE: tb/testbench.sv
// Testbench of force_progress_led_bar_core: drives position and force
// transactions, predicts the lit segment and colour levels, checks each result.
// Depends on fplb_pkg and the RTL of the core.
`timescale 1ns / 1ps

class led_bar_scoreboard;
    typedef struct {
        logic [2:0] seg;
        logic [7:0] red;
        logic [7:0] green;
        logic [3:0] idle;
    } led_result_t;

    led_result_t pending[$];
    int errors;
    int checked;
    logic signed [23:0] path_start[3];
    logic signed [23:0] path_end[3];

    function new();
        errors = 0;
        checked = 0;
        for (int i = 0; i < 3; i++)
        begin
            path_start[i] = '0;
            path_end[i] = '0;
        end
    endfunction

    function void set_register(fplb_pkg::cfg_reg_t idx, logic signed [23:0] v);
        if (idx < fplb_pkg::CFG_END_X)
            path_start[idx] = v;
        else
            path_end[idx - fplb_pkg::CFG_END_X] = v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function logic [7:0] red_for_force(logic signed [15:0] fx, logic signed [15:0] fz);
        longint signed ax;
        longint signed az;
        longint signed q;
        longint signed t;
        longint unsigned a;
        longint unsigned g;
        longint unsigned den;
        longint unsigned r;
        longint unsigned coef[9];
        coef = '{63520, 61565, 57835, 51039, 39750, 24109, 8869, 1200, 22};
        ax = fx;
        az = fz;
        q = (int_sqrt(4 * (ax * ax + az * az)) + 1) >> 1;
        t = q - 960;
        if (t > 256)
            t = 256;
        if (t < -256)
            t = -256;
        a = (t < 0) ? -t : t;
        g = 65536;
        for (int i = 0; i < 9; i++)
            if (a[i])
                g = (g * coef[i] + 32768) >> 16;
        den = 65536 + g;
        if (t >= 0)
            r = (2 * 180 * 65536 + den) / (2 * den);
        else
            r = (2 * 180 * g + den) / (2 * den);
        if (r > 180)
            r = 180;
        return r[7:0];
    endfunction

    function void note_input(logic signed [23:0] px, logic signed [23:0] py,
                             logic signed [23:0] pz, logic signed [15:0] fx,
                             logic signed [15:0] fz);
        longint signed p[3];
        longint signed d;
        longint unsigned d2;
        longint unsigned l2;
        led_result_t r;
        p = '{px, py, pz};
        d2 = 0;
        l2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = p[i] - longint'(path_start[i]);
            d2 += d * d;
            d = longint'(path_end[i]) - longint'(path_start[i]);
            l2 += d * d;
        end
        r.seg = 0;
        for (int k = 1; k < 5; k++)
            if (25 * d2 >= k * k * l2)
                r.seg++;
        r.red = red_for_force(fx, fz);
        r.green = 8'd180 - r.red;
        r.idle = 4'd10;
        pending.push_back(r);
    endfunction

    function void check_result(logic [2:0] seg, logic [7:0] red, logic [7:0] green,
                               logic [3:0] idle);
        led_result_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result seg=%0d red=%0d", seg, red);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (seg !== e.seg)
        begin
            $error("lit_segment expected %0d actual %0d", e.seg, seg);
            errors++;
        end
        if (red !== e.red)
        begin
            $error("red_level expected %0d actual %0d", e.red, red);
            errors++;
        end
        if (green !== e.green)
        begin
            $error("green_level expected %0d actual %0d", e.green, green);
            errors++;
        end
        if (idle !== e.idle)
        begin
            $error("idle_level expected %0d actual %0d", e.idle, idle);
            errors++;
        end
    endfunction
endclass

module testbench;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    fplb_pkg::coord_t pos_x;
    fplb_pkg::coord_t pos_y;
    fplb_pkg::coord_t pos_z;
    fplb_pkg::force_t force_x;
    fplb_pkg::force_t force_z;
    logic out_valid;
    logic out_stall;
    logic [2:0] lit_segment;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [3:0] idle_level;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    fplb_pkg::coord_t cfg_data;

    led_bar_scoreboard board;
    bit idle_on;
    int sent;

    force_progress_led_bar_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .force_x(force_x), .force_z(force_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .lit_segment(lit_segment), .red_level(red_level),
        .green_level(green_level), .idle_level(idle_level),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(lit_segment, red_level, green_level, idle_level);
        out_stall <= idle_on && ($urandom_range(0, 99) < 30);
    end

    task automatic write_reg(fplb_pkg::cfg_reg_t idx, fplb_pkg::coord_t v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(idx, v);
    endtask

    task automatic send_item(fplb_pkg::coord_t px, fplb_pkg::coord_t py,
                             fplb_pkg::coord_t pz, fplb_pkg::force_t fx,
                             fplb_pkg::force_t fz);
        while (idle_on && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        force_x <= fx;
        force_z <= fz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(px, py, pz, fx, fz);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic fplb_pkg::coord_t rand_coord(int span);
        if (span == 0)
            return fplb_pkg::coord_t'($urandom);
        return fplb_pkg::coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic load_path(fplb_pkg::coord_t sx, fplb_pkg::coord_t sy,
                             fplb_pkg::coord_t sz, fplb_pkg::coord_t ex,
                             fplb_pkg::coord_t ey, fplb_pkg::coord_t ez);
        write_reg(fplb_pkg::CFG_START_X, sx);
        write_reg(fplb_pkg::CFG_START_Y, sy);
        write_reg(fplb_pkg::CFG_START_Z, sz);
        write_reg(fplb_pkg::CFG_END_X, ex);
        write_reg(fplb_pkg::CFG_END_Y, ey);
        write_reg(fplb_pkg::CFG_END_Z, ez);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item(int span);
        fplb_pkg::coord_t px;
        fplb_pkg::coord_t py;
        fplb_pkg::coord_t pz;
        fplb_pkg::force_t fx;
        fplb_pkg::force_t fz;
        int t;
        px = board.path_start[0] + rand_coord(span);
        py = board.path_start[1] + rand_coord(span);
        pz = board.path_start[2] + rand_coord(span);
        if ($urandom_range(0, 9) == 0)
        begin
            px = rand_coord(0);
            py = rand_coord(0);
            pz = rand_coord(0);
        end
        t = $urandom_range(0, 3);
        if (t == 0)
        begin
            fx = fplb_pkg::force_t'($urandom);
            fz = fplb_pkg::force_t'($urandom);
        end
        else
        begin
            fx = fplb_pkg::force_t'($urandom_range(0, 2600) - 1300);
            fz = fplb_pkg::force_t'($urandom_range(0, 2600) - 1300);
        end
        send_item(px, py, pz, fx, fz);
    endtask

    initial
    begin
        board = new();
        rst_n = 0;
        in_valid = 0;
        out_stall = 0;
        cfg_valid = 0;
        cfg_index = fplb_pkg::CFG_START_X;
        cfg_data = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        force_x = '0;
        force_z = '0;
        idle_on = 1;
        sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-length path after reset
        send_item(24'sd5, -24'sd3, 24'sd0, 16'sd0, 16'sd0);
        send_item(24'sd0, 24'sd0, 24'sd0, 16'sd960, 16'sd0);
        drain();

        load_path(24'sd0, 24'sd0, 24'sd0, 24'sd1000, 24'sd0, 24'sd0);
        for (int k = 0; k <= 5; k++)
            send_item(fplb_pkg::coord_t'(200 * k), 24'sd0, 24'sd0,
                      fplb_pkg::force_t'(704 + 100 * k), 16'sd0);
        send_item(24'sd199, 24'sd0, 24'sd0, 16'sd1216, 16'sd0);
        send_item(24'sd120, 24'sd160, 24'sd0, -16'sd1217, 16'sd0);
        send_item(24'sd0, 24'sd0, 24'sd0, 16'sd959, 16'sd1);
        send_item(-24'sd3000, 24'sd0, 24'sd0, 16'sd578, 16'sd768);
        send_item(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF);
        send_item(24'sh800000, 24'sh800000, 24'sh800000, 16'sh8000, 16'sh8000);
        send_item(24'sh555555, 24'shAAAAAA, 24'sh555555, 16'sh5555, 16'shAAAA);
        send_item(24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 16'shAAAA, 16'sh5555);
        drain();

        load_path(24'sh800000, 24'sh800000, 24'sh800000,
                  24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_item(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'sd0, -16'sd960);
        send_item(24'sh800000, 24'sh800000, 24'sh800000, 16'sd1, 16'sd1);
        send_item(24'sd0, 24'sd0, 24'sd0, -16'sd1000, 16'sd0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            int span;
            span = (phase % 3 == 0) ? 0 : 5000 << (phase * 3);
            load_path(rand_coord(0), rand_coord(0), rand_coord(0),
                      rand_coord(0), rand_coord(0), rand_coord(0));
            if (span != 0)
                load_path(rand_coord(1000), rand_coord(1000), rand_coord(1000),
                          rand_coord(span), rand_coord(span), rand_coord(span));
            idle_on = (phase != 2);
            for (int i = 0; i < 145; i++)
                random_item(span);
            if (phase == 3)
            begin
                in_valid <= 1'b0;
                while (board.pending.size() != 0)
                    @(posedge clk);
            end
            drain();
        end

        $display("Covered %0d transactions over directed boundary cases and random paths.",
                 sent);
        $display("Compared %0d results, %0d mismatches.", board.checked, board.errors);
        if (board.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
